>>> sv/pvns_pkg.sv
// shared constants and types for the periodic value-noise sampler
// no dependencies
package pvns_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int ENTRY_BITS = 6;
	localparam int CFG_BITS   = 16;
	localparam int COUNT_BITS = 7;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_LATTICE_COLS = 2'd2;
	localparam logic [1:0] CFG_LATTICE_ROWS = 2'd3;

	typedef struct packed {
		logic [ENTRY_BITS-1:0] row;
		logic [ENTRY_BITS-1:0] col;
		logic [FRAC_BITS-1:0]  value;
	} load_word_t;

endpackage

>>> sv/pvns_locate.sv
// one axis: coordinate to wrapped lattice index and smoothstep fraction
// pipelined restoring dividers and a two-stage smoothstep; uses pvns_pkg
module pvns_locate #(
	parameter int CW = 7,
	parameter int QW = 6
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic [pvns_pkg::COORD_BITS-1:0]  coord,
	input  logic [CW-1:0]                    count,
	input  logic [pvns_pkg::COORD_BITS-1:0]  size,
	output logic [QW-1:0]                    idx,
	output logic [pvns_pkg::FRAC_BITS-1:0]   shaped
);

	localparam int CB = pvns_pkg::COORD_BITS;
	localparam int FB = pvns_pkg::FRAC_BITS;
	localparam int N2 = QW + FB;
	localparam int PW = CB + CW;

	// coord mod size
	logic [CB-1:0] r1_q [CB];
	logic [CB-1:0] d1_q [CB];

	for (genvar k = 0; k < CB; k++) begin : g_div1
		logic [CB-1:0] rin, din;
		logic [CB:0]   trial;
		logic          ge;
		assign rin   = (k == 0) ? '0 : r1_q[(k == 0) ? 0 : k-1];
		assign din   = (k == 0) ? coord : d1_q[(k == 0) ? 0 : k-1];
		assign trial = {rin, din[CB-1]};
		assign ge    = trial >= {1'b0, size};
		always_ff @(posedge clk) begin
			if (en) begin
				r1_q[k] <= ge ? CB'(trial - {1'b0, size}) : trial[CB-1:0];
				d1_q[k] <= {din[CB-2:0], 1'b0};
			end
		end
	end

	logic [PW-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PW'(r1_q[CB-1]) * PW'(count);
		end
	end

	// (prod << 16) / size, integer part stays below count
	logic [CB-1:0] a2_q [N2];
	logic [N2-1:0] q2_q [N2];

	for (genvar k = 0; k < N2; k++) begin : g_div2
		logic [CB-1:0] ain;
		logic [N2-1:0] qin;
		logic [CB:0]   trial;
		logic          ge;
		assign ain   = (k == 0) ? CB'(prod_q >> QW) : a2_q[(k == 0) ? 0 : k-1];
		assign qin   = (k == 0) ? {prod_q[QW-1:0], {FB{1'b0}}} : q2_q[(k == 0) ? 0 : k-1];
		assign trial = {ain, qin[N2-1]};
		assign ge    = trial >= {1'b0, size};
		always_ff @(posedge clk) begin
			if (en) begin
				a2_q[k] <= ge ? CB'(trial - {1'b0, size}) : trial[CB-1:0];
				q2_q[k] <= {qin[N2-2:0], ge};
			end
		end
	end

	logic [FB-1:0]   t;
	logic [2*FB-1:0] tt_s1;
	logic [FB+1:0]   w_s1;
	logic [QW-1:0]   ix_s1, ix_s2;
	logic [FB-1:0]   sh_s2;
	logic [3*FB+1:0] cube;

	assign t    = q2_q[N2-1][FB-1:0];
	assign cube = (3*FB+2)'(tt_s1) * (3*FB+2)'(w_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			tt_s1 <= (2*FB)'(t) * (2*FB)'(t);
			w_s1  <= (FB+2)'(3 * (1 << FB)) - {1'b0, t, 1'b0};
			ix_s1 <= q2_q[N2-1][N2-1:FB];
			sh_s2 <= FB'(cube >> (2*FB));
			ix_s2 <= ix_s1;
		end
	end

	assign idx    = ix_s2;
	assign shaped = sh_s2;

endmodule

>>> sv/pvns_lattice.sv
// lattice word store: two copies, each with one write and two read ports
// read data registered; uses pvns_pkg only by its callers
module pvns_lattice #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int VB    = 16
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [VB-1:0] wdata,
	input  logic [AW-1:0] ra0,
	input  logic [AW-1:0] ra1,
	input  logic [AW-1:0] rb0,
	input  logic [AW-1:0] rb1,
	output logic [VB-1:0] da0,
	output logic [VB-1:0] da1,
	output logic [VB-1:0] db0,
	output logic [VB-1:0] db1
);

	logic [VB-1:0] mem_a [DEPTH];
	logic [VB-1:0] mem_b [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_a[waddr] <= wdata;
			end
			da0 <= mem_a[ra0];
			da1 <= mem_a[ra1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_b[waddr] <= wdata;
			end
			db0 <= mem_b[rb0];
			db1 <= mem_b[rb1];
		end
	end

endmodule

>>> sv/periodic_value_noise_sampler_core.sv
// top level of the periodic value-noise sampler
// uses pvns_pkg, pvns_locate and pvns_lattice
//
// Takes one word per cycle, load or sample, while the pipe is not held, and returns
// one noise word per sample in order. Each axis is located by two bit-per-stage
// dividers; four lattice reads per cycle come from two copies of the store with
// two read ports each. A load takes effect for every sample accepted after it. The
// whole pipe holds only while a finished word waits at the output and another is
// behind it. The lattice store has no reset; only written entries may be sampled.
module periodic_value_noise_sampler_core #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 64,
	parameter int VALUE_BITS  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [1:0]                            cfg_index,
	input  logic [pvns_pkg::CFG_BITS-1:0]         cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  kind,
	input  logic [pvns_pkg::ENTRY_BITS-1:0]       entry_row,
	input  logic [pvns_pkg::ENTRY_BITS-1:0]       entry_col,
	input  logic [pvns_pkg::FRAC_BITS-1:0]        entry_value,
	input  logic [pvns_pkg::COORD_BITS-1:0]       sample_x,
	input  logic [pvns_pkg::COORD_BITS-1:0]       sample_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [pvns_pkg::FRAC_BITS-1:0]        noise_value
);

	localparam int CB    = pvns_pkg::COORD_BITS;
	localparam int FB    = pvns_pkg::FRAC_BITS;
	localparam int VB    = VALUE_BITS;
	localparam int MAXM  = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
	localparam int CW    = $clog2(MAXM + 1);
	localparam int QW    = $clog2(MAXM);
	localparam int LAT   = CB + 1 + QW + FB + 2;
	localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = VB + FB + 1;
	localparam int SHR   = (VB >= FB) ? VB - FB : 0;
	localparam int SHL   = (VB < FB) ? FB - VB : 0;

	// configuration
	logic [CB-1:0]                   frame_width_q, frame_height_q;
	logic [pvns_pkg::COUNT_BITS-1:0] cols_q, rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= CB'(64);
			frame_height_q <= CB'(64);
			cols_q         <= pvns_pkg::COUNT_BITS'(2);
			rows_q         <= pvns_pkg::COUNT_BITS'(2);
		end else if (cfg_write) begin
			case (cfg_index)
				pvns_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				pvns_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				pvns_pkg::CFG_LATTICE_COLS: cols_q <= cfg_data[pvns_pkg::COUNT_BITS-1:0];
				pvns_pkg::CFG_LATTICE_ROWS: rows_q <= cfg_data[pvns_pkg::COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	logic [CW-1:0] cols_c, rows_c;
	logic [CB-1:0] width_c, height_c;

	always_comb begin
		if (cols_q < pvns_pkg::COUNT_BITS'(2)) cols_c = CW'(2);
		else if (int'(cols_q) > MAX_COLUMNS) cols_c = CW'(MAX_COLUMNS);
		else cols_c = CW'(cols_q);
		if (rows_q < pvns_pkg::COUNT_BITS'(2)) rows_c = CW'(2);
		else if (int'(rows_q) > MAX_ROWS) rows_c = CW'(MAX_ROWS);
		else rows_c = CW'(rows_q);
		width_c  = (frame_width_q == '0) ? CB'(1) : frame_width_q;
		height_c = (frame_height_q == '0) ? CB'(1) : frame_height_q;
	end

	// pipeline advance
	logic en, in_fire;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	assign en       = !(vld_s5 && out_valid && !out_ready);
	assign in_ready = en;
	assign in_fire  = in_valid && en;

	// item line alongside the locate units
	logic [LAT-1:0]       smp_line_q, ld_line_q;
	pvns_pkg::load_word_t ld_word_q [LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_line_q <= '0;
			ld_line_q  <= '0;
		end else if (en) begin
			smp_line_q <= {smp_line_q[LAT-2:0], in_fire && kind == pvns_pkg::KIND_SAMPLE};
			ld_line_q  <= {ld_line_q[LAT-2:0], in_fire && kind == pvns_pkg::KIND_LOAD};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ld_word_q[0] <= '{row: entry_row, col: entry_col, value: entry_value};
			for (int k = 1; k < LAT; k++) begin
				ld_word_q[k] <= ld_word_q[k-1];
			end
		end
	end

	logic [QW-1:0] ix, iy;
	logic [FB-1:0] sx, sy;

	pvns_locate #(.CW(CW), .QW(QW)) u_loc_x (
		.clk(clk), .en(en), .coord(sample_x), .count(cols_c), .size(width_c),
		.idx(ix), .shaped(sx)
	);

	pvns_locate #(.CW(CW), .QW(QW)) u_loc_y (
		.clk(clk), .en(en), .coord(sample_y), .count(rows_c), .size(height_c),
		.idx(iy), .shaped(sy)
	);

	// address stage
	logic [QW-1:0] jx, jy;
	logic [AW-1:0] ra0, ra1, rb0, rb1, waddr;
	logic          we;
	logic [VB-1:0] wdata;
	pvns_pkg::load_word_t ldw;

	always_comb begin
		ldw   = ld_word_q[LAT-1];
		jx    = (int'(ix) + 1 == int'(cols_c)) ? '0 : QW'(int'(ix) + 1);
		jy    = (int'(iy) + 1 == int'(rows_c)) ? '0 : QW'(int'(iy) + 1);
		ra0   = AW'(int'(iy) * MAX_COLUMNS + int'(ix));
		ra1   = AW'(int'(iy) * MAX_COLUMNS + int'(jx));
		rb0   = AW'(int'(jy) * MAX_COLUMNS + int'(ix));
		rb1   = AW'(int'(jy) * MAX_COLUMNS + int'(jx));
		waddr = AW'(int'(ldw.row) * MAX_COLUMNS + int'(ldw.col));
		wdata = VB'(ldw.value);
		we    = en && ld_line_q[LAT-1] && int'(ldw.row) < MAX_ROWS
			&& int'(ldw.col) < MAX_COLUMNS;
	end

	logic [VB-1:0] da0, da1, db0, db1;

	pvns_lattice #(.DEPTH(DEPTH), .AW(AW), .VB(VB)) u_lattice (
		.clk(clk), .en(en), .we(we), .waddr(waddr), .wdata(wdata),
		.ra0(ra0), .ra1(ra1), .rb0(rb0), .rb1(rb1),
		.da0(da0), .da1(da1), .db0(db0), .db1(db1)
	);

	// blend
	logic [FB-1:0]  sx_s1, sy_s1, sy_s2, sy_s3;
	logic [FB:0]    wx, wy;
	logic [PW-1:0]  pa_s2, pb_s2, pc_s2, pd_s2;
	logic [PW-1:0]  top_s3, bot_s3;
	logic [PW-1:0]  p1_s4, p2_s4;
	logic [2*FB:0]  p3_s4, p4_s4;
	logic [2*FB+1:0] low_sum;
	logic [PW-1:0]  x_s5;
	logic [PW+FB-1:0] ext;
	logic [FB-1:0]  res;

	assign wx = (FB+1)'(1 << FB) - {1'b0, sx_s1};
	assign wy = (FB+1)'(1 << FB) - {1'b0, sy_s3};

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1  <= sx;
			sy_s1  <= sy;
			pa_s2  <= PW'(da0) * PW'(wx);
			pb_s2  <= PW'(da1) * PW'(sx_s1);
			pc_s2  <= PW'(db0) * PW'(wx);
			pd_s2  <= PW'(db1) * PW'(sx_s1);
			sy_s2  <= sy_s1;
			top_s3 <= pa_s2 + pb_s2;
			bot_s3 <= pc_s2 + pd_s2;
			sy_s3  <= sy_s2;
			p1_s4  <= PW'(top_s3[PW-1:FB]) * PW'(wy);
			p2_s4  <= PW'(bot_s3[PW-1:FB]) * PW'(sy_s3);
			p3_s4  <= (2*FB+1)'(top_s3[FB-1:0]) * (2*FB+1)'(wy);
			p4_s4  <= (2*FB+1)'(bot_s3[FB-1:0]) * (2*FB+1)'(sy_s3);
			x_s5   <= p1_s4 + p2_s4 + PW'(low_sum >> FB);
		end
	end

	always_comb begin
		low_sum = (2*FB+2)'(p3_s4) + (2*FB+2)'(p4_s4);
		ext     = (PW+FB)'(x_s5 >> FB);
		ext     = (ext >> SHR) << SHL;
		res     = (ext > (PW+FB)'(65535)) ? 16'hFFFF : ext[FB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= smp_line_q[LAT-1];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en && vld_s5) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_s5) begin
			noise_value <= res;
		end
	end

endmodule
